// ----- hdl/pga_pkg.sv -----
// Shared constants and types for the pairwise gravity accumulator.
`timescale 1ns / 1ps
package pga_pkg;

  localparam int MAX_BODIES_DEF = 256;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [CFG_W-1:0] MPP_RST  = 32'd65536;
  localparam logic [CFG_W-1:0] GRAV_RST = 32'd0;
  localparam logic [CFG_W-1:0] SOFT_RST = 32'd66;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MPP  = 2'd0,
    CFG_GRAV = 2'd1,
    CFG_SOFT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    FUNC_ACC = 1'b0,
    FUNC_CLR = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_MUL1,
    ST_SQRT,
    ST_MUL2,
    ST_DIV,
    ST_WRA,
    ST_WRB,
    ST_DONE
  } state_t;

  // Step counts of the sequencer phases (last step index).
  localparam logic [4:0] MUL1_LAST = 5'd6;
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] MUL2_LAST = 5'd10;
  localparam logic [4:0] DIV_LAST  = 5'd31;

endpackage

// ----- hdl/pairwise_gravity_accumulator.sv -----
// Pairwise softened gravity step with per-body acceleration accumulators.
`timescale 1ns / 1ps
// Sequence: an accumulate word goes from acceptance through 2 reads, 7 multiply
// steps, 32 root steps, 11 multiply steps, 32 divide steps and 2 writes to the
// hand-off to the result register; a clear word goes straight to the 2 writes.
// Throughput: one word at a time, set by the root and divide iterations and
// the shared 32x32 multiplier. Reset: synchronous, active low; afterwards a
// clearing pass writes zero to all MAX_BODIES entries, one per cycle.
module pairwise_gravity_accumulator #(
  parameter int MAX_BODIES = pga_pkg::MAX_BODIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_body_a,
  input  logic [7:0]  in_body_b,
  input  logic signed [23:0] in_pos_a_x,
  input  logic signed [23:0] in_pos_a_y,
  input  logic signed [23:0] in_pos_b_x,
  input  logic signed [23:0] in_pos_b_y,
  input  logic [31:0] in_mass_a,
  input  logic [31:0] in_mass_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_acc_a_x,
  output logic signed [31:0] out_acc_a_y,
  output logic signed [31:0] out_acc_b_x,
  output logic signed [31:0] out_acc_b_y,
  input  logic        cfg_we,
  input  logic [pga_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pga_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BODIES - 1);

  // Reduce an 8-bit body number modulo MAX_BODIES by restoring subtraction.
  function automatic logic [IDX_W-1:0] body_idx(input logic [7:0] v);
    logic [24:0] r;
    logic [24:0] d;
    r = {17'd0, v};
    for (int k = 7; k >= 0; k--) begin
      d = 25'(MAX_BODIES) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[IDX_W-1:0];
  endfunction

  // Add a signed increment (magnitude plus sign) and clamp to 32 bits.
  function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [31:0] mag,
                                          input logic neg);
    logic signed [33:0] s;
    logic signed [33:0] inc;
    inc = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    s   = $signed({{2{acc[31]}}, acc}) + inc;
    if (s > 34'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (s < -34'sd2147483648) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  // Quotient bit 31 set means the increment reached the cap of 2^31.
  function automatic logic [31:0] lane_mag(input logic [31:0] q, input logic zero);
    if (zero) begin
      return 32'd0;
    end
    return q[31] ? 32'h8000_0000 : {1'b0, q[30:0]};
  endfunction

  pga_pkg::state_t state_r, state_nxt;

  logic [4:0]       cnt_r;
  logic [IDX_W-1:0] clr_cnt_r;

  logic [31:0] mpp_r, grav_r, soft_r;

  // Latched word
  logic             func_r;
  logic [IDX_W-1:0] ia_r, ib_r;
  logic signed [23:0] pax_r, pay_r, pbx_r, pby_r;
  logic [31:0]      mass_a_r, mass_b_r;

  // Datapath
  logic [23:0]  magx_r, magy_r;
  logic         negx_r, negy_r;
  logic [31:0]  op_a, op_b;
  logic [63:0]  prod_r;
  logic [30:0]  dx_r, dy_r;
  logic [63:0]  r2_r, ka_r, kb_r;
  logic [63:0]  sq_n_r, sq_res_r, sq_bit_r;
  logic [127:0] den_r;
  logic [127:0] num_r [4];
  logic [31:0]  q_r [4];
  logic [31:0]  root_dist;
  logic         dist_zero;
  logic [63:0]  sq_t;
  logic [30:0]  sat_d;
  logic signed [24:0] dpx, dpy;

  // Accumulator store
  logic [31:0]      mem_x [MAX_BODIES];
  logic [31:0]      mem_y [MAX_BODIES];
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  logic [31:0]      mem_wx, mem_wy;
  logic [31:0]      rdx_r, rdy_r;

  logic [31:0] old_ax_r, old_ay_r, old_bx_r, old_by_r;
  logic [31:0] new_ax_r, new_ay_r, new_bx_r, new_by_r;
  logic [31:0] new_ax, new_ay, new_bx, new_by, base_bx, base_by;
  logic        same_body;
  logic        is_clr;

  logic        out_valid_r;
  logic [31:0] out_ax_r, out_ay_r, out_bx_r, out_by_r;
  logic        out_load;

  assign root_dist = sq_res_r[31:0];
  assign dist_zero = (sq_res_r == 64'd0);
  assign sq_t      = sq_res_r + sq_bit_r;
  assign same_body = (ia_r == ib_r);
  assign is_clr    = (func_r == pga_pkg::FUNC_CLR);
  assign sat_d     = (prod_r[63:39] != 25'd0) ? 31'h7FFF_FFFF : prod_r[38:8];
  assign dpx       = {pbx_r[23], pbx_r} - {pax_r[23], pax_r};
  assign dpy       = {pby_r[23], pby_r} - {pay_r[23], pay_r};

  // New accumulator values; a clear word writes zero.
  assign new_ax  = is_clr ? 32'd0 : sat_add(old_ax_r, lane_mag(q_r[0], dist_zero), negx_r);
  assign new_ay  = is_clr ? 32'd0 : sat_add(old_ay_r, lane_mag(q_r[1], dist_zero), negy_r);
  // Forward body_a's result when both names point at one entry.
  assign base_bx = same_body ? new_ax_r : old_bx_r;
  assign base_by = same_body ? new_ay_r : old_by_r;
  assign new_bx  = is_clr ? 32'd0 : sat_add(base_bx, lane_mag(q_r[2], dist_zero), !negx_r);
  assign new_by  = is_clr ? 32'd0 : sat_add(base_by, lane_mag(q_r[3], dist_zero), !negy_r);

  assign out_load = (state_r == pga_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pga_pkg::ST_INIT: if (clr_cnt_r == LAST_IDX) state_nxt = pga_pkg::ST_IDLE;
      pga_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_func == pga_pkg::FUNC_CLR) ? pga_pkg::ST_WRA : pga_pkg::ST_RDA;
        end
      end
      pga_pkg::ST_RDA:  state_nxt = pga_pkg::ST_RDB;
      pga_pkg::ST_RDB:  state_nxt = pga_pkg::ST_MUL1;
      pga_pkg::ST_MUL1: if (cnt_r == pga_pkg::MUL1_LAST) state_nxt = pga_pkg::ST_SQRT;
      pga_pkg::ST_SQRT: if (cnt_r == pga_pkg::SQRT_LAST) state_nxt = pga_pkg::ST_MUL2;
      pga_pkg::ST_MUL2: if (cnt_r == pga_pkg::MUL2_LAST) state_nxt = pga_pkg::ST_DIV;
      pga_pkg::ST_DIV:  if (cnt_r == pga_pkg::DIV_LAST) state_nxt = pga_pkg::ST_WRA;
      pga_pkg::ST_WRA:  state_nxt = pga_pkg::ST_WRB;
      pga_pkg::ST_WRB:  state_nxt = pga_pkg::ST_DONE;
      pga_pkg::ST_DONE: if (out_load) state_nxt = pga_pkg::ST_IDLE;
      default:          state_nxt = pga_pkg::ST_INIT;
    endcase
  end

  // Control outputs: handshake, memory ports, multiplier operands
  always_comb begin
    in_stall = (state_r != pga_pkg::ST_IDLE);
    mem_we   = 1'b0;
    mem_wa   = ia_r;
    mem_wx   = new_ax;
    mem_wy   = new_ay;
    mem_ra   = ia_r;
    op_a     = 32'd0;
    op_b     = 32'd0;
    case (state_r)
      pga_pkg::ST_INIT: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wx = 32'd0;
        mem_wy = 32'd0;
      end
      pga_pkg::ST_RDB: mem_ra = ib_r;
      pga_pkg::ST_WRA: mem_we = 1'b1;
      pga_pkg::ST_WRB: begin
        mem_we = 1'b1;
        mem_wa = ib_r;
        mem_wx = new_bx;
        mem_wy = new_by;
      end
      pga_pkg::ST_MUL1: begin
        case (cnt_r)
          5'd0:    begin op_a = {8'd0, magx_r}; op_b = mpp_r; end
          5'd1:    begin op_a = {8'd0, magy_r}; op_b = mpp_r; end
          5'd2:    begin op_a = {1'b0, dx_r};   op_b = {1'b0, dx_r}; end
          5'd3:    begin op_a = {1'b0, dy_r};   op_b = {1'b0, dy_r}; end
          5'd4:    begin op_a = grav_r;         op_b = mass_b_r; end
          5'd5:    begin op_a = grav_r;         op_b = mass_a_r; end
          default: begin op_a = 32'd0;          op_b = 32'd0; end
        endcase
      end
      pga_pkg::ST_MUL2: begin
        case (cnt_r)
          5'd0:    begin op_a = r2_r[31:0];  op_b = root_dist; end
          5'd1:    begin op_a = r2_r[63:32]; op_b = root_dist; end
          5'd2:    begin op_a = ka_r[31:0];  op_b = {1'b0, dx_r}; end
          5'd3:    begin op_a = ka_r[63:32]; op_b = {1'b0, dx_r}; end
          5'd4:    begin op_a = ka_r[31:0];  op_b = {1'b0, dy_r}; end
          5'd5:    begin op_a = ka_r[63:32]; op_b = {1'b0, dy_r}; end
          5'd6:    begin op_a = kb_r[31:0];  op_b = {1'b0, dx_r}; end
          5'd7:    begin op_a = kb_r[63:32]; op_b = {1'b0, dx_r}; end
          5'd8:    begin op_a = kb_r[31:0];  op_b = {1'b0, dy_r}; end
          5'd9:    begin op_a = kb_r[63:32]; op_b = {1'b0, dy_r}; end
          default: begin op_a = 32'd0;       op_b = 32'd0; end
        endcase
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pga_pkg::ST_INIT;
      cnt_r       <= 5'd0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      mpp_r       <= pga_pkg::MPP_RST;
      grav_r      <= pga_pkg::GRAV_RST;
      soft_r      <= pga_pkg::SOFT_RST;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= (state_nxt != state_r) ? 5'd0 : cnt_r + 5'd1;
      clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          pga_pkg::CFG_MPP:  mpp_r  <= cfg_wdata;
          pga_pkg::CFG_GRAV: grav_r <= cfg_wdata;
          pga_pkg::CFG_SOFT: soft_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Accumulator store: one write and one registered read per cycle per axis
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[mem_wa] <= mem_wx;
      mem_y[mem_wa] <= mem_wy;
    end
    rdx_r <= mem_x[mem_ra];
    rdy_r <= mem_y[mem_ra];
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    case (state_r)
      pga_pkg::ST_IDLE: begin
        if (in_valid) begin
          func_r   <= in_func;
          ia_r     <= body_idx(in_body_a);
          ib_r     <= body_idx(in_body_b);
          pax_r    <= in_pos_a_x;
          pay_r    <= in_pos_a_y;
          pbx_r    <= in_pos_b_x;
          pby_r    <= in_pos_b_y;
          mass_a_r <= in_mass_a;
          mass_b_r <= in_mass_b;
        end
      end
      pga_pkg::ST_RDA: begin
        // Offset from body_a to body_b as magnitude and sign
        negx_r <= dpx[24];
        negy_r <= dpy[24];
        magx_r <= dpx[24] ? 24'(-dpx) : dpx[23:0];
        magy_r <= dpy[24] ? 24'(-dpy) : dpy[23:0];
      end
      pga_pkg::ST_RDB: begin
        old_ax_r <= rdx_r;
        old_ay_r <= rdy_r;
      end
      pga_pkg::ST_MUL1: begin
        case (cnt_r)
          5'd0: begin
            old_bx_r <= rdx_r;
            old_by_r <= rdy_r;
          end
          5'd1: dx_r <= sat_d;
          5'd2: dy_r <= sat_d;
          5'd3: r2_r <= prod_r + {16'd0, soft_r, 16'd0};
          5'd4: r2_r <= r2_r + prod_r;
          5'd5: ka_r <= prod_r;
          default: begin
            kb_r     <= prod_r;
            sq_n_r   <= r2_r;
            sq_res_r <= 64'd0;
            sq_bit_r <= 64'h4000_0000_0000_0000;
          end
        endcase
      end
      pga_pkg::ST_SQRT: begin
        // One result bit per cycle
        if (sq_n_r >= sq_t) begin
          sq_n_r   <= sq_n_r - sq_t;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      pga_pkg::ST_MUL2: begin
        // Divisor is r2*dist, held pre-shifted by 31 for the first quotient bit
        case (cnt_r)
          5'd1:  den_r    <= {64'd0, prod_r} << 31;
          5'd2:  den_r    <= den_r + ({64'd0, prod_r} << 63);
          5'd3:  num_r[0] <= {64'd0, prod_r} << 24;
          5'd4:  num_r[0] <= num_r[0] + ({64'd0, prod_r} << 56);
          5'd5:  num_r[1] <= {64'd0, prod_r} << 24;
          5'd6:  num_r[1] <= num_r[1] + ({64'd0, prod_r} << 56);
          5'd7:  num_r[2] <= {64'd0, prod_r} << 24;
          5'd8:  num_r[2] <= num_r[2] + ({64'd0, prod_r} << 56);
          5'd9:  num_r[3] <= {64'd0, prod_r} << 24;
          5'd10: num_r[3] <= num_r[3] + ({64'd0, prod_r} << 56);
          default: begin
            for (int i = 0; i < 4; i++) begin
              q_r[i] <= 32'd0;
            end
          end
        endcase
      end
      pga_pkg::ST_DIV: begin
        // Four restoring dividers share the shifted divisor
        for (int i = 0; i < 4; i++) begin
          if (num_r[i] >= den_r) begin
            num_r[i] <= num_r[i] - den_r;
          end
          q_r[i] <= {q_r[i][30:0], (num_r[i] >= den_r)};
        end
        den_r <= den_r >> 1;
      end
      pga_pkg::ST_WRA: begin
        new_ax_r <= new_ax;
        new_ay_r <= new_ay;
      end
      pga_pkg::ST_WRB: begin
        new_bx_r <= new_bx;
        new_by_r <= new_by;
      end
      default: ;
    endcase
    if (out_load) begin
      out_ax_r <= same_body ? new_bx_r : new_ax_r;
      out_ay_r <= same_body ? new_by_r : new_ay_r;
      out_bx_r <= new_bx_r;
      out_by_r <= new_by_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_acc_a_x = out_ax_r;
  assign out_acc_a_y = out_ay_r;
  assign out_acc_b_x = out_bx_r;
  assign out_acc_b_y = out_by_r;

endmodule

// ----- dv/pairwise_gravity_accumulator_tb.sv -----
// Self-checking testbench for the pairwise gravity accumulator.
`timescale 1ns / 1ps
module pairwise_gravity_accumulator_tb;

  // One input word: a pair of bodies with positions and masses, or a clear.
  typedef struct {
    pga_pkg::func_t     func;
    logic [7:0]         body_a;
    logic [7:0]         body_b;
    logic signed [23:0] pos_a_x;
    logic signed [23:0] pos_a_y;
    logic signed [23:0] pos_b_x;
    logic signed [23:0] pos_b_y;
    logic [31:0]        mass_a;
    logic [31:0]        mass_b;
  } pair_word_t;

  // Accumulator values of both bodies after one word.
  typedef struct {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
  } accel_word_t;

  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_func = 1'b0;
  logic [7:0]         in_body_a = '0;
  logic [7:0]         in_body_b = '0;
  logic signed [23:0] in_pos_a_x = '0;
  logic signed [23:0] in_pos_a_y = '0;
  logic signed [23:0] in_pos_b_x = '0;
  logic signed [23:0] in_pos_b_y = '0;
  logic [31:0]        in_mass_a = '0;
  logic [31:0]        in_mass_b = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [31:0] out_acc_a_x;
  logic signed [31:0] out_acc_a_y;
  logic signed [31:0] out_acc_b_x;
  logic signed [31:0] out_acc_b_y;
  logic               cfg_we = 1'b0;
  logic [pga_pkg::CFG_IDX_W-1:0] cfg_index = pga_pkg::CFG_MPP;
  logic [pga_pkg::CFG_W-1:0]     cfg_wdata = '0;

  pairwise_gravity_accumulator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_body_a   (in_body_a),
    .in_body_b   (in_body_b),
    .in_pos_a_x  (in_pos_a_x),
    .in_pos_a_y  (in_pos_a_y),
    .in_pos_b_x  (in_pos_b_x),
    .in_pos_b_y  (in_pos_b_y),
    .in_mass_a   (in_mass_a),
    .in_mass_b   (in_mass_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_acc_a_x (out_acc_a_x),
    .out_acc_a_y (out_acc_a_y),
    .out_acc_b_x (out_acc_b_x),
    .out_acc_b_y (out_acc_b_y),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Words waiting to be sent, and accumulator values waiting to come back.
  pair_word_t  pending_words[$];
  accel_word_t accel_expected[$];

  // Shadow copy of the block's registers and accumulator store.
  logic [31:0]        mpp_shadow  = pga_pkg::MPP_RST;
  logic [31:0]        grav_shadow = pga_pkg::GRAV_RST;
  logic [31:0]        soft_shadow = pga_pkg::SOFT_RST;
  logic signed [31:0] accel_x[pga_pkg::MAX_BODIES_DEF];
  logic signed [31:0] accel_y[pga_pkg::MAX_BODIES_DEF];

  int error_count = 0;
  int words_sent = 0;
  int clears_sent = 0;
  int results_checked = 0;
  logic hold_req = 1'b0;

  initial begin
    for (int i = 0; i < pga_pkg::MAX_BODIES_DEF; i++) begin
      accel_x[i] = '0;
      accel_y[i] = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Pixel offset scaled to Q23.8 meters: magnitude plus separate sign.
  function automatic logic [63:0] scaled_offset(logic signed [23:0] pa,
                                                logic signed [23:0] pb,
                                                output logic neg);
    longint     dp;
    logic [63:0] mag;
    dp  = longint'(pb) - longint'(pa);
    neg = dp < 0;
    mag = neg ? 64'(-dp) : 64'(dp);
    mag = (mag * 64'(mpp_shadow)) >> 8;
    return (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] rem, root, bitv;
    rem  = n;
    root = '0;
    bitv = 64'h1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // floor(k*d*2^24 / (r2*dist)), capped at 2^31.
  function automatic logic [63:0] pull_magnitude(logic [63:0] k, logic [63:0] d,
                                                 logic [63:0] r2, logic [63:0] root_d);
    logic [127:0] num, den, q;
    if (k == 0 || d == 0 || r2 == 0 || root_d == 0) return '0;
    num = (128'(k) * 128'(d)) << 24;
    den = 128'(r2) * 128'(root_d);
    q   = num / den;
    return (q >= 128'h8000_0000) ? 64'h8000_0000 : 64'(q);
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] acc,
                                                 logic [63:0] mag, logic neg);
    longint v;
    v = longint'(acc) + (neg ? -longint'(mag) : longint'(mag));
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return 32'(v);
  endfunction

  // Apply one word to the shadow store and return the values it leaves.
  function automatic accel_word_t gravity_step(pair_word_t w);
    accel_word_t r;
    logic        nx, ny;
    logic [63:0] dx, dy, r2, root_d, ka, kb;
    int          ia, ib;
    ia = w.body_a;
    ib = w.body_b;
    if (w.func == pga_pkg::FUNC_CLR) begin
      accel_x[ia] = '0;
      accel_y[ia] = '0;
      accel_x[ib] = '0;
      accel_y[ib] = '0;
    end else begin
      dx     = scaled_offset(w.pos_a_x, w.pos_b_x, nx);
      dy     = scaled_offset(w.pos_a_y, w.pos_b_y, ny);
      r2     = dx * dx + dy * dy + (64'(soft_shadow) << 16);
      root_d = int_sqrt(r2);
      ka     = 64'(grav_shadow) * 64'(w.mass_b);
      kb     = 64'(grav_shadow) * 64'(w.mass_a);
      // body_a first, so a repeated body sees both increments in order
      accel_x[ia] = sat_add(accel_x[ia], pull_magnitude(ka, dx, r2, root_d), nx);
      accel_y[ia] = sat_add(accel_y[ia], pull_magnitude(ka, dy, r2, root_d), ny);
      accel_x[ib] = sat_add(accel_x[ib], pull_magnitude(kb, dx, r2, root_d), !nx);
      accel_y[ib] = sat_add(accel_y[ib], pull_magnitude(kb, dy, r2, root_d), !ny);
    end
    r.a_x = accel_x[ia];
    r.a_y = accel_y[ia];
    r.b_x = accel_x[ib];
    r.b_y = accel_y[ib];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: bursts of words with random gaps between them
  // ---------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    pair_word_t w, cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Predict on the accepted word, sampled before this edge's updates.
      if (in_valid && !in_stall) begin
        cur.func    = pga_pkg::func_t'(in_func);
        cur.body_a  = in_body_a;
        cur.body_b  = in_body_b;
        cur.pos_a_x = in_pos_a_x;
        cur.pos_a_y = in_pos_a_y;
        cur.pos_b_x = in_pos_b_x;
        cur.pos_b_y = in_pos_b_y;
        cur.mass_a  = in_mass_a;
        cur.mass_b  = in_mass_b;
        accel_expected.push_back(gravity_step(cur));
        words_sent++;
        if (cur.func == pga_pkg::FUNC_CLR) clears_sent++;
      end
      // Hold a stalled word; otherwise pick the next word or idle.
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_func    <= w.func;
          in_body_a  <= w.body_a;
          in_body_b  <= w.body_b;
          in_pos_a_x <= w.pos_a_x;
          in_pos_a_y <= w.pos_a_y;
          in_pos_b_x <= w.pos_b_x;
          in_pos_b_y <= w.pos_b_y;
          in_mass_a  <= w.mass_a;
          in_mass_b  <= w.mass_b;
          in_valid   <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stall pattern in one of four randomly chosen modes, plus one
  // long hold-off on request
  // ---------------------------------------------------------------------
  int   stall_mode = 0;
  int   rx_cycle = 0;
  int   hold_left = 0;
  logic hold_taken = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_stall  <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and checks
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    accel_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (accel_expected.size() == 0) begin
        $display("ERROR %0t: result word with nothing expected", $realtime);
        error_count++;
      end else begin
        exp_w = accel_expected.pop_front();
        results_checked++;
        if (out_acc_a_x !== exp_w.a_x) report_mismatch("acc_a_x", out_acc_a_x, exp_w.a_x);
        if (out_acc_a_y !== exp_w.a_y) report_mismatch("acc_a_y", out_acc_a_y, exp_w.a_y);
        if (out_acc_b_x !== exp_w.b_x) report_mismatch("acc_b_x", out_acc_b_x, exp_w.b_x);
        if (out_acc_b_y !== exp_w.b_y) report_mismatch("acc_b_y", out_acc_b_y, exp_w.b_y);
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", STUCK_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic pair_word_t pair_word(pga_pkg::func_t f, int a, int b,
                                           int ax, int ay, int bx, int by,
                                           logic [31:0] ma, logic [31:0] mb);
    pair_word_t w;
    w.func    = f;
    w.body_a  = 8'(a);
    w.body_b  = 8'(b);
    w.pos_a_x = 24'(ax);
    w.pos_a_y = 24'(ay);
    w.pos_b_x = 24'(bx);
    w.pos_b_y = 24'(by);
    w.mass_a  = ma;
    w.mass_b  = mb;
    return w;
  endfunction

  function automatic logic [31:0] spread32();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic logic signed [23:0] rand_pos(logic signed [23:0] base);
    case ($urandom_range(0, 9))
      0, 1, 2: return 24'($urandom);
      3:       return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
      default: return base + 24'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  // Mostly pair steps among a few bodies so the sums build up; some clears
  // and some words on any body.
  function automatic pair_word_t random_word();
    pair_word_t w;
    logic signed [23:0] bx, by;
    bx = 24'($urandom_range(0, 65535)) - 24'sd32768;
    by = 24'($urandom_range(0, 65535)) - 24'sd32768;
    w.func   = ($urandom_range(0, 9) == 0) ? pga_pkg::FUNC_CLR : pga_pkg::FUNC_ACC;
    w.body_a = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    w.body_b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    w.pos_a_x = rand_pos(bx);
    w.pos_a_y = rand_pos(by);
    if ($urandom_range(0, 9) == 0) begin
      w.pos_b_x = w.pos_a_x;
      w.pos_b_y = w.pos_a_y;
    end else begin
      w.pos_b_x = rand_pos(bx);
      w.pos_b_y = rand_pos(by);
    end
    w.mass_a = ($urandom_range(0, 1) == 0) ? $urandom : spread32();
    w.mass_b = ($urandom_range(0, 1) == 0) ? $urandom : spread32();
    if ($urandom_range(0, 19) == 0) w.mass_a = '0;
    return w;
  endfunction

  task automatic write_regs(logic [31:0] mpp, logic [31:0] grav, logic [31:0] soft_val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= pga_pkg::CFG_MPP;
    cfg_wdata <= mpp;
    @(posedge clk);
    cfg_index <= pga_pkg::CFG_GRAV;
    cfg_wdata <= grav;
    @(posedge clk);
    cfg_index <= pga_pkg::CFG_SOFT;
    cfg_wdata <= soft_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    mpp_shadow  = mpp;
    grav_shadow = grav;
    soft_shadow = soft_val;
  endtask

  // Sender pause: wait until everything queued has gone and come back.
  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() > 0 || in_valid || accel_expected.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unit scale, moderate constant.
    write_regs(32'h0001_0000, 32'h0100_0000, 32'd66);
    pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 0, 1, 0, 0, 256, 0, 1000, 1000));
    pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 0, 1, 0, 0, 0, 256, 1000, 1000));
    pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 1, 0, -8388608, -8388608,
                                      8388607, 8388607, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 255, 0, 8388607, -8388608,
                                      -8388608, 8388607, 32'hFFFF_FFFF, 1));
    pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 2, 3, 100, 100, 100, 100,
                                      5000, 5000));
    pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 2, 3, 0, 0, 512, 512, 0, 0));
    pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 2, 3, 0, 0, -512, 512, 0, 7));
    pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 4, 4, 0, 0, 300, -300, 9, 2));
    pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 4, 4, 0, 0, 1, 1,
                                      32'hFFFF_FFFF, 3));
    for (int i = 0; i < 6; i++)
      pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 5, 6, 0, 0, 1, 0,
                                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(pair_word(pga_pkg::FUNC_CLR, 0, 255, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(pair_word(pga_pkg::FUNC_CLR, 5, 5, -1, -1, -1, -1,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 5, 255, 0, 0, 0, 0, 1, 1));
    drain();

    // No softening: coincident positions leave the sums alone.
    write_regs(32'h0001_0000, 32'h0100_0000, 32'd0);
    pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 7, 8, 500, -500, 500, -500,
                                      100, 100));
    pending_words.push_back(pair_word(pga_pkg::FUNC_ACC, 7, 8, 0, 0, 0, 1, 100, 100));
    for (int i = 0; i < 60; i++) pending_words.push_back(random_word());
    drain();

    // Random phases over several register settings, extremes first.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: write_regs(32'h0, 32'h0, 32'h0);
        2: write_regs(32'h0, 32'hFFFF_FFFF, 32'h1);
        3: write_regs(32'hFFFF_FFFF, 32'h1, 32'h0);
        default: write_regs(spread32(), spread32(), spread32());
      endcase
      // Long receiver hold-off while the sender keeps offering words.
      if (ph == 4) hold_req = 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) pending_words.push_back(random_word());
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Covered %0d words (%0d clears), %0d result words checked,",
             words_sent, clears_sent, results_checked);
    $display("%0d register settings including all-zero and all-one extremes.", PHASES + 2);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
